// ===== sv/dvd_pkg.sv =====
// Package with the shared types and fixed widths of the DBPSK varicode deframer.
package dvd_pkg;

    localparam int CODEWORD_W = 14;
    localparam int CODE_LEN_W = 4;
    localparam int ACCUM_W    = 15;
    localparam int CNT_W      = 5;

    typedef logic [CODEWORD_W-1:0] codeword_t;
    typedef logic [CODE_LEN_W-1:0] code_len_t;
    typedef logic [ACCUM_W-1:0]    accum_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    typedef struct packed {
        logic valid;
        logic has_bit;
    } stage_ctl_t;

endpackage

// ===== sv/dbpsk_symbol_varicode_deframer_core.sv =====
// Top level of the DBPSK symbol decision and varicode deframer.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+---------------------------
//   symbol  | in_valid, in_stall  | sym_i, sym_q
//   result  | out_valid, out_stall| codeword, codeword_len
//
// One symbol is accepted per cycle while in_stall is low. A symbol's products
// are registered in the input stage, and the decision and framing update then
// land in the result register. Reset clears the previous symbol, the framing
// state and both valid flags. A stalled result holds the result register, and
// the input stage then raises in_stall once it holds a request of its own.
module dbpsk_symbol_varicode_deframer_core #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int MAX_CODE_BITS = 14
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] sym_i,
    input  logic signed [SAMPLE_WIDTH-1:0] sym_q,
    output logic                           out_valid,
    input  logic                           out_stall,
    output dvd_pkg::codeword_t             codeword,
    output dvd_pkg::code_len_t             codeword_len
);

    dvd_pkg::stage_ctl_t              stg;
    logic signed [2*SAMPLE_WIDTH-1:0] prod_i;
    logic signed [2*SAMPLE_WIDTH-1:0] prod_q;
    logic                             adv;
    logic                             take;

    assign in_stall = stg.valid && !adv;
    assign take     = in_valid && !in_stall;

    dvd_diff_mult #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_diff_mult (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .adv    (adv),
        .sym_i  (sym_i),
        .sym_q  (sym_q),
        .stg    (stg),
        .prod_i (prod_i),
        .prod_q (prod_q)
    );

    dvd_framer #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .MAX_CODE_BITS(MAX_CODE_BITS)
    ) u_framer (
        .clk          (clk),
        .rst_n        (rst_n),
        .stg          (stg),
        .prod_i       (prod_i),
        .prod_q       (prod_q),
        .out_stall    (out_stall),
        .adv          (adv),
        .out_valid    (out_valid),
        .codeword     (codeword),
        .codeword_len (codeword_len)
    );

endmodule

// ===== sv/dvd_diff_mult.sv =====
// Input stage: zero-vector substitution and the two products against the previous symbol.
module dvd_diff_mult #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           take,
    input  logic                           adv,
    input  logic signed [SAMPLE_WIDTH-1:0] sym_i,
    input  logic signed [SAMPLE_WIDTH-1:0] sym_q,
    output dvd_pkg::stage_ctl_t            stg,
    output logic signed [2*SAMPLE_WIDTH-1:0] prod_i,
    output logic signed [2*SAMPLE_WIDTH-1:0] prod_q
);

    logic signed [SAMPLE_WIDTH-1:0]   si;
    logic signed [SAMPLE_WIDTH-1:0]   prev_i_reg;
    logic signed [SAMPLE_WIDTH-1:0]   prev_q_reg;
    logic                             primed_reg;
    dvd_pkg::stage_ctl_t              stg_reg;
    dvd_pkg::stage_ctl_t              stg_next;
    logic signed [2*SAMPLE_WIDTH-1:0] prod_i_reg;
    logic signed [2*SAMPLE_WIDTH-1:0] prod_q_reg;
    logic signed [2*SAMPLE_WIDTH-1:0] prod_i_next;
    logic signed [2*SAMPLE_WIDTH-1:0] prod_q_next;

    // A zero vector is treated as phase zero, i.e. the unit vector (1, 0).
    always_comb
    begin
        si = sym_i;
        if (sym_i == '0 && sym_q == '0)
        begin
            si = {{(SAMPLE_WIDTH-1){1'b0}}, 1'b1};
        end
        prod_i_next = (2*SAMPLE_WIDTH)'(prev_i_reg) * (2*SAMPLE_WIDTH)'(si);
        prod_q_next = (2*SAMPLE_WIDTH)'(prev_q_reg) * (2*SAMPLE_WIDTH)'(sym_q);
    end

    always_comb
    begin
        stg_next = stg_reg;
        if (take)
        begin
            stg_next.valid   = 1'b1;
            stg_next.has_bit = primed_reg;
        end
        else if (adv)
        begin
            stg_next.valid   = 1'b0;
            stg_next.has_bit = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_reg    <= '0;
            primed_reg <= 1'b0;
            prev_i_reg <= '0;
            prev_q_reg <= '0;
        end
        else
        begin
            stg_reg <= stg_next;
            if (take)
            begin
                primed_reg <= 1'b1;
                prev_i_reg <= si;
                prev_q_reg <= sym_q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            prod_i_reg <= prod_i_next;
            prod_q_reg <= prod_q_next;
        end
    end

    assign stg    = stg_reg;
    assign prod_i = prod_i_reg;
    assign prod_q = prod_q_reg;

endmodule

// ===== sv/dvd_framer.sv =====
// Bit decision from the dot product, varicode framing and the result register.
module dvd_framer #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int MAX_CODE_BITS = 14
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dvd_pkg::stage_ctl_t              stg,
    input  logic signed [2*SAMPLE_WIDTH-1:0] prod_i,
    input  logic signed [2*SAMPLE_WIDTH-1:0] prod_q,
    input  logic                             out_stall,
    output logic                             adv,
    output logic                             out_valid,
    output dvd_pkg::codeword_t               codeword,
    output dvd_pkg::code_len_t               codeword_len
);

    localparam int DOT_W = 2 * SAMPLE_WIDTH + 1;

    logic signed [DOT_W-1:0] dot;
    logic                    dbit;
    logic                    fire;

    dvd_pkg::accum_t    accum_reg;
    dvd_pkg::accum_t    accum_next;
    dvd_pkg::code_len_t count_reg;
    dvd_pkg::code_len_t count_next;
    logic               in_cw_reg;
    logic               in_cw_next;
    logic               zp_reg;
    logic               zp_next;
    logic               emit;
    logic               out_valid_reg;
    logic               out_valid_next;
    dvd_pkg::codeword_t codeword_reg;
    dvd_pkg::code_len_t len_reg;

    assign dot  = {prod_i[2*SAMPLE_WIDTH-1], prod_i} + {prod_q[2*SAMPLE_WIDTH-1], prod_q};
    assign dbit = !dot[DOT_W-1] && (dot != '0);
    assign adv  = !out_valid_reg || !out_stall;
    assign fire = stg.valid && adv;

    always_comb
    begin
        dvd_pkg::accum_t acc;
        dvd_pkg::cnt_t   cnt;
        acc        = accum_reg;
        cnt        = {1'b0, count_reg};
        accum_next = accum_reg;
        count_next = count_reg;
        in_cw_next = in_cw_reg;
        zp_next    = zp_reg;
        emit       = 1'b0;
        if (fire && stg.has_bit)
        begin
            if (dbit)
            begin
                if (zp_reg)
                begin
                    acc = {acc[dvd_pkg::ACCUM_W-2:0], 1'b0};
                    cnt = cnt + dvd_pkg::CNT_W'(1);
                end
                acc = {acc[dvd_pkg::ACCUM_W-2:0], 1'b1};
                cnt = cnt + dvd_pkg::CNT_W'(1);
                if (cnt > dvd_pkg::CNT_W'(MAX_CODE_BITS))
                begin
                    accum_next = '0;
                    count_next = '0;
                    in_cw_next = 1'b0;
                    zp_next    = 1'b0;
                end
                else
                begin
                    accum_next = acc;
                    count_next = cnt[dvd_pkg::CODE_LEN_W-1:0];
                    in_cw_next = 1'b1;
                    zp_next    = 1'b0;
                end
            end
            else if (in_cw_reg)
            begin
                if (zp_reg)
                begin
                    emit = (count_reg != '0) &&
                           ({1'b0, count_reg} <= dvd_pkg::CNT_W'(MAX_CODE_BITS));
                    accum_next = '0;
                    count_next = '0;
                    in_cw_next = 1'b0;
                    zp_next    = 1'b0;
                end
                else
                begin
                    zp_next = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg     <= '0;
            count_reg     <= '0;
            in_cw_reg     <= 1'b0;
            zp_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            accum_reg     <= accum_next;
            count_reg     <= count_next;
            in_cw_reg     <= in_cw_next;
            zp_reg        <= zp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            codeword_reg <= accum_reg[dvd_pkg::CODEWORD_W-1:0];
            len_reg      <= count_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign codeword     = codeword_reg;
    assign codeword_len = len_reg;

endmodule

// ===== sv/dvd_checker.sv =====
// Port-level checker for the deframer core and its bind statement.
module dvd_checker #(
    parameter int MAX_CODE_BITS = 14
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_stall,
    input logic                    out_valid,
    input logic                    out_stall,
    input dvd_pkg::codeword_t      codeword,
    input dvd_pkg::code_len_t      codeword_len
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(codeword) && $stable(codeword_len))
        else $error("stalled result changed");

    // The input side only waits behind a stalled result.
    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> codeword_len != '0 &&
                      codeword_len <= dvd_pkg::CODE_LEN_W'(MAX_CODE_BITS))
        else $error("codeword length out of range");

    // A codeword always ends on a 1, since a trailing zero is held pending.
    a_last_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> codeword[0])
        else $error("codeword ends in zero");

    // The first bit of a codeword is a 1 and nothing lies above it.
    a_first_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> codeword_len > dvd_pkg::CODE_LEN_W'(dvd_pkg::CODEWORD_W) ||
                      codeword_len == '0 ||
                      (codeword >> (codeword_len - dvd_pkg::CODE_LEN_W'(1))) ==
                      dvd_pkg::codeword_t'(1))
        else $error("codeword does not start with a one");

endmodule

bind dbpsk_symbol_varicode_deframer_core dvd_checker #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
) u_dvd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .codeword     (codeword),
    .codeword_len (codeword_len)
);
